/* src/lru_key_value_cache_core_macros.svh */
// Assertion macros for the LRU key-value cache core.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef LRU_KEY_VALUE_CACHE_CORE_MACROS_SVH
`define LRU_KEY_VALUE_CACHE_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define LKVC_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define LKVC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/lkvc_pkg.sv */
// Shared types and constants for the LRU key-value cache core.
// No dependencies; imported by lkvc_cell and the top level.
package lkvc_pkg;

    localparam int KEY_BITS      = 32;
    localparam int WORD_BITS     = 32;
    localparam int OCC_BITS      = 5;
    localparam int IN_DATA_BITS  = 64;   // key, write_value
    localparam int OUT_DATA_BITS = 40;   // read_value, occupancy, pad
    localparam int APB_ADDR_BITS = 3;
    localparam int APB_DATA_BITS = 32;

    localparam logic [OCC_BITS-1:0] CAP_RESET = OCC_BITS'(16);

    // register index, taken from paddr[2]
    localparam logic REG_CAPACITY = 1'b0;

    typedef enum logic {
        CMD_GET = 1'b0,
        CMD_PUT = 1'b1
    } t_cmd;

    // per-cell control from the sequencer
    typedef struct packed {
        logic cmp_en;    // register the key compare
        logic shift_en;  // take the neighbour's (or head) entry
    } t_cell_ctl;

endpackage

/* src/lkvc_cell.sv */
// One recency-ordered slot of the LRU cache chain: key, word, valid, match flag.
// Depends on lkvc_pkg.
module lkvc_cell
    import lkvc_pkg::*;
#(
    parameter int VAL_W = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cell_ctl           i_ctl,
    input  logic [KEY_BITS-1:0] i_req_key,
    input  logic                i_valid,
    input  logic [KEY_BITS-1:0] i_key,
    input  logic [VAL_W-1:0]    i_value,
    output logic                o_valid,
    output logic [KEY_BITS-1:0] o_key,
    output logic [VAL_W-1:0]    o_value,
    output logic                o_match
);

    logic                r_valid;
    logic                r_match;
    logic [KEY_BITS-1:0] r_key;
    logic [VAL_W-1:0]    r_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_match <= 1'b0;
        end else begin
            if (i_ctl.shift_en) begin
                r_valid <= i_valid;
                r_match <= 1'b0;
            end else if (i_ctl.cmp_en) begin
                r_match <= r_valid && (r_key == i_req_key);
            end
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (i_ctl.shift_en) begin
            r_key   <= i_key;
            r_value <= i_value;
        end
    end

    assign o_valid = r_valid;
    assign o_key   = r_key;
    assign o_value = r_value;
    assign o_match = r_match;

endmodule

/* src/lru_key_value_cache_core.sv */
// LRU key-value cache. Each beat on the slave stream is a get or a put on a 32-bit key;
// each one gives exactly one result beat (found flag, read word, occupancy). The entries
// sit in a chain of cells kept in recency order: cell 0 holds the most recent entry and
// valid cells form an unbroken run from cell 0. An access moves its entry to cell 0 and
// every cell ahead of it hands its contents one step down the chain; a put's new key enters at
// cell 0 and, once occupancy has reached the capacity register, the entry falling off
// the end of the valid run is the least recent one. Sequence: each item passes through
// acceptance, a registered key compare in every cell, and a chain shift with result
// capture, and the next item is taken only once the current one has reached the result
// register; the update step waits while the output register still holds an untaken beat.
// The result register lets the next item be accepted while a result waits. The user must
// write capacity through the APB port (address 0) only while idle; the block does not
// enforce this. Zero acts as one and values above ENTRIES act as ENTRIES.
// Depends on lkvc_pkg, lkvc_cell and lru_key_value_cache_core_macros.svh.
`include "lru_key_value_cache_core_macros.svh"

module lru_key_value_cache_core
    import lkvc_pkg::*;
#(
    parameter int ENTRIES   = 16,
    parameter int DATA_BITS = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // slave stream
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    input  logic [IN_DATA_BITS-1:0]  s_axis_tdata,   // [31:0] key, [63:32] write_value
    input  logic                     s_axis_tuser,   // [0] cmd
    // master stream
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    output logic [OUT_DATA_BITS-1:0] m_axis_tdata,   // [31:0] read_value, [36:32] occupancy
    output logic                     m_axis_tuser,   // [0] found
    // config
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready
);

    // stored word width: the word never carries more than WORD_BITS
    localparam int VAL_W  = (DATA_BITS < WORD_BITS) ? DATA_BITS : WORD_BITS;
    localparam int LEVELS = $clog2(ENTRIES);
    localparam int OCC_MAX = (1 << OCC_BITS) - 1;
    localparam logic [OCC_BITS-1:0] CAP_MAX =
        (ENTRIES > OCC_MAX) ? OCC_BITS'(OCC_MAX) : OCC_BITS'(ENTRIES);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MATCH,
        ST_UPDATE
    } t_state;

    t_state                r_state;
    t_cmd                  r_req_cmd;
    logic [KEY_BITS-1:0]   r_req_key;
    logic [VAL_W-1:0]      r_req_value;
    logic [OCC_BITS-1:0]   r_count;
    logic [OCC_BITS-1:0]   n_count;
    logic [OCC_BITS-1:0]   r_capacity;
    logic                  r_out_valid;
    logic                  r_out_found;
    logic [WORD_BITS-1:0]  r_out_value;
    logic [OCC_BITS-1:0]   r_out_occ;

    // chain signals
    t_cell_ctl             w_ctl       [ENTRIES];
    logic                  w_nb_valid  [ENTRIES];
    logic [KEY_BITS-1:0]   w_nb_key    [ENTRIES];
    logic [VAL_W-1:0]      w_nb_value  [ENTRIES];
    logic [KEY_BITS-1:0]   w_key       [ENTRIES];
    logic [VAL_W-1:0]      w_value     [ENTRIES];
    logic [ENTRIES-1:0]    w_valid;
    logic [ENTRIES-1:0]    w_match;
    logic [ENTRIES-1:0]    w_before;   // some match in a more recent cell
    logic                  w_hit;
    logic [VAL_W-1:0]      w_sel_value;
    logic [VAL_W-1:0]      w_head_value;
    logic [OCC_BITS-1:0]   w_cap_eff;
    logic                  w_evict;
    logic                  w_go;
    logic                  w_put;

    // ---------------------------------------------------------------- config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
        end else if (psel && penable && pwrite && pready && (paddr[2] == REG_CAPACITY)) begin
            r_capacity <= pwdata[OCC_BITS-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_CAPACITY) ? APB_DATA_BITS'(r_capacity) : '0;

    always_comb begin
        if (r_capacity == '0) begin
            w_cap_eff = OCC_BITS'(1);
        end else if (r_capacity > CAP_MAX) begin
            w_cap_eff = CAP_MAX;
        end else begin
            w_cap_eff = r_capacity;
        end
    end

    // ---------------------------------------------------------------- hit detect
    // parallel prefix OR over the registered match flags, log depth
    always_comb begin
        logic [ENTRIES-1:0] pre [LEVELS+1];
        pre[0] = w_match;
        for (int k = 1; k <= LEVELS; k++) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (i >= (1 << (k - 1))) begin
                    pre[k][i] = pre[k-1][i] | pre[k-1][i - (1 << (k - 1))];
                end else begin
                    pre[k][i] = pre[k-1][i];
                end
            end
        end
        w_before[0] = 1'b0;
        for (int i = 1; i < ENTRIES; i++) begin
            w_before[i] = pre[LEVELS][i-1];
        end
        w_hit = pre[LEVELS][ENTRIES-1];
    end

    // keys are unique among valid cells, so at most one match: plain OR select
    always_comb begin
        w_sel_value = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            w_sel_value = w_sel_value | (w_match[i] ? w_value[i] : '0);
        end
    end

    // ---------------------------------------------------------------- chain control
    assign w_put        = (r_req_cmd == CMD_PUT);
    assign w_go         = (r_state == ST_UPDATE) && (!r_out_valid || m_axis_tready);
    assign w_evict      = (r_count >= w_cap_eff);
    assign w_head_value = w_put ? r_req_value : w_sel_value;

    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            w_ctl[i].cmp_en = (r_state == ST_MATCH);
            if (i == 0) begin
                w_ctl[i].shift_en = w_go && (w_hit || w_put);
                w_nb_valid[i]     = 1'b1;
                w_nb_key[i]       = r_req_key;
                w_nb_value[i]     = w_head_value;
            end else begin
                if (w_hit) begin
                    // cells from the head down to the hit entry move one step
                    w_ctl[i].shift_en = w_go && !w_before[i];
                end else begin
                    // new key: whole valid run moves; on eviction its last entry drops
                    w_ctl[i].shift_en = w_go && w_put && (w_evict ? w_valid[i] : w_valid[i-1]);
                end
                w_nb_valid[i] = w_valid[i-1];
                w_nb_key[i]   = w_key[i-1];
                w_nb_value[i] = w_value[i-1];
            end
        end
    end

    always_comb begin
        if (!w_hit && w_put && !w_evict) begin
            n_count = r_count + OCC_BITS'(1);
        end else begin
            n_count = r_count;
        end
    end

    // ---------------------------------------------------------------- cells
    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        lkvc_cell #(
            .VAL_W (VAL_W)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (w_ctl[g]),
            .i_req_key (r_req_key),
            .i_valid   (w_nb_valid[g]),
            .i_key     (w_nb_key[g]),
            .i_value   (w_nb_value[g]),
            .o_valid   (w_valid[g]),
            .o_key     (w_key[g]),
            .o_value   (w_value[g]),
            .o_match   (w_match[g])
        );
    end

    // ---------------------------------------------------------------- sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // a new result may replace one taken in the same cycle
            if (w_go) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_state <= ST_MATCH;
                    end
                end
                ST_MATCH: begin
                    r_state <= ST_UPDATE;
                end
                ST_UPDATE: begin
                    if (w_go) begin
                        r_state <= ST_IDLE;
                        r_count <= n_count;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // request and result payload
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_req_cmd   <= t_cmd'(s_axis_tuser);
            r_req_key   <= s_axis_tdata[KEY_BITS-1:0];
            r_req_value <= s_axis_tdata[KEY_BITS +: VAL_W];
        end
        if (w_go) begin
            r_out_found <= w_hit;
            r_out_value <= (w_hit && !w_put) ? WORD_BITS'(w_sel_value) : '0;
            r_out_occ   <= n_count;
        end
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_found;
    assign m_axis_tdata  = {{(OUT_DATA_BITS - WORD_BITS - OCC_BITS){1'b0}}, r_out_occ, r_out_value};

    // ---------------------------------------------------------------- checks
    `LKVC_ASSERT_IMPLY(a_valid_run_matches_count, i_clk, i_rst_n, 1'b1, ($countones(w_valid) == int'(r_count)), "valid cells disagree with occupancy")
    `LKVC_ASSERT_IMPLY(a_count_in_range, i_clk, i_rst_n, 1'b1, (r_count <= CAP_MAX), "occupancy beyond the chain")
    `LKVC_ASSERT_IMPLY(a_single_match, i_clk, i_rst_n, (r_state == ST_UPDATE), $onehot0(w_match), "more than one cell matched the key")
    `LKVC_ASSERT_NEXT(a_result_follows_update, i_clk, i_rst_n, w_go, (m_axis_tvalid && (r_state == ST_IDLE)), "update gave no result beat")

endmodule
